FILE: src/sfd_pkg.sv
`default_nettype none

package sfd_pkg;

  localparam int unsigned FrameBytesDef = 26;
  localparam logic [3:0]  ZeroLimitRst  = 4'd4;
  localparam int unsigned IndexW        = 5;

  typedef enum logic [2:0] {
    PH_WAIT   = 3'd0,
    PH_HEADER = 3'd1,
    PH_FIRST  = 3'd2,
    PH_DECODE = 3'd3,
    PH_IGNORE = 3'd4
  } phase_e;

  typedef struct packed {
    logic              kind;
    logic [7:0]        data_byte;
    logic [IndexW-1:0] byte_index;
    logic              last_of_frame;
  } result_t;

  // rising-ones sync pattern for a given shift
  function automatic logic [7:0] rise_pat(input logic [2:0] sh);
    logic [7:0] p;
    if (sh == 3'd0) begin
      p = 8'hFF;
    end else begin
      p = 8'hFF >> (4'd8 - {1'b0, sh});
    end
    return p;
  endfunction

  function automatic logic [7:0] fall_pat(input logic [2:0] sh);
    return 8'hFF << sh;
  endfunction

endpackage

`default_nettype wire

FILE: src/sfd_in_reg.sv
`default_nettype none

module sfd_in_reg (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  output logic            ready_o,
  input  wire logic [7:0] byte_i,
  output logic            valid_o,
  input  wire logic       take_i,
  output logic [7:0]      byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign byte_o  = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      byte_q <= byte_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/sfd_core.sv
`default_nettype none

module sfd_core #(
  parameter int unsigned FrameBytes = sfd_pkg::FrameBytesDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [3:0] cfg_data_i,
  input  wire logic       fire_i,
  input  wire logic [7:0] byte_i,
  output logic            res_valid_o,
  output sfd_pkg::result_t res_o
);

  import sfd_pkg::*;

  localparam int unsigned CntW = $clog2(FrameBytes + 1);

  phase_e          phase_q, phase_d;
  logic [2:0]      shift_q, shift_d;
  logic [1:0]      need_q, need_d;
  logic [1:0]      seen_q, seen_d;
  logic [7:0]      prev_q, prev_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [3:0]      zrun_q, zrun_d;
  logic [3:0]      limit_q;

  logic [CntW-1:0] cnt_inc;
  logic [4:0]      zrun_inc;
  logic [15:0]     joined;
  logic            rise_hit;
  logic [2:0]      rise_idx;

  assign cnt_inc  = cnt_q + CntW'(1);
  assign zrun_inc = {1'b0, zrun_q} + 5'd1;
  assign joined   = {prev_q, byte_i} >> shift_q;

  always_comb begin
    rise_hit = 1'b0;
    rise_idx = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (byte_i == rise_pat(3'(i))) begin
        rise_hit = 1'b1;
        rise_idx = 3'(i);
      end
    end
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    shift_d = shift_q;
    need_d  = need_q;
    seen_d  = seen_q;
    prev_d  = prev_q;
    cnt_d   = cnt_q;
    zrun_d  = zrun_q;
    case (phase_q)
      PH_HEADER: begin
        if (seen_q < need_q && byte_i == 8'hFF) begin
          seen_d = seen_q + 2'd1;
        end else if (seen_q == need_q && byte_i == fall_pat(shift_q)) begin
          phase_d = PH_FIRST;
        end else begin
          zrun_d  = 4'd0;
          phase_d = PH_IGNORE;
        end
      end
      PH_FIRST: begin
        prev_d  = byte_i;
        cnt_d   = '0;
        phase_d = PH_DECODE;
      end
      PH_DECODE: begin
        prev_d = byte_i;
        cnt_d  = cnt_inc;
        if (cnt_inc >= CntW'(FrameBytes)) begin
          phase_d = PH_WAIT;
          cnt_d   = '0;
        end
      end
      PH_IGNORE: begin
        if (byte_i == 8'h00) begin
          if (zrun_inc > {1'b0, limit_q}) begin
            phase_d = PH_WAIT;
          end else begin
            zrun_d = zrun_inc[3:0];
          end
        end else begin
          zrun_d = 4'd0;
        end
      end
      default: begin
        phase_d = PH_WAIT;
        if (byte_i != 8'h00 && rise_hit) begin
          phase_d = PH_HEADER;
          shift_d = rise_idx;
          need_d  = (rise_idx == 3'd0) ? 2'd1 : 2'd2;
          seen_d  = 2'd0;
        end
      end
    endcase
  end

  // result
  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    case (phase_q)
      PH_DECODE: begin
        res_valid_o         = fire_i;
        res_o.data_byte     = joined[7:0];
        res_o.byte_index    = IndexW'(cnt_q);
        res_o.last_of_frame = (cnt_inc >= CntW'(FrameBytes));
      end
      PH_IGNORE: begin
        if (byte_i == 8'h00 && zrun_inc > {1'b0, limit_q}) begin
          res_valid_o = fire_i;
          res_o.kind  = 1'b1;
        end
      end
      default: begin
        res_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      shift_q <= 3'd0;
      need_q  <= 2'd0;
      seen_q  <= 2'd0;
      prev_q  <= 8'd0;
      cnt_q   <= '0;
      zrun_q  <= 4'd0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      shift_q <= shift_d;
      need_q  <= need_d;
      seen_q  <= seen_d;
      prev_q  <= prev_d;
      cnt_q   <= cnt_d;
      zrun_q  <= zrun_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= ZeroLimitRst;
    end else if (cfg_we_i) begin
      limit_q <= cfg_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/sfd_out_skid.sv
`default_nettype none

module sfd_out_skid (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire sfd_pkg::result_t res_i,
  output logic                  ready_o,
  output logic                  valid_o,
  input  wire logic             pop_ready_i,
  output sfd_pkg::result_t      res_o
);

  import sfd_pkg::*;

  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;
  logic    pop;

  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign res_o   = out_q;
  assign pop     = out_valid_q && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push_i;
      end
    end else if (push_i) begin
      if (!out_valid_q) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (push_i) begin
        out_q <= res_i;
      end
    end else if (push_i) begin
      if (!out_valid_q) begin
        out_q <= res_i;
      end else begin
        skid_q <= res_i;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/shifted_sync_frame_deframer.sv
// Shifted-sync frame deframer.
// Path: a byte is registered in sfd_in_reg, then its result is registered in
// sfd_out_skid. Throughput: one byte per cycle while m_tready_i accepts results;
// the output skid register lets input continue while a result is held.
// Reset (rst_ni low, async): waiting for sync, zero_run_limit back to 4.
`default_nettype none

module shifted_sync_frame_deframer #(
  parameter int unsigned FrameBytes = sfd_pkg::FrameBytesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [7:0]  s_tdata_i,   // [7:0] rx_byte
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic [15:0]      m_tdata_o,   // [7:0] data_byte, [12:8] byte_index
  output logic             m_tuser_o,   // [0] kind
  output logic             m_tlast_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [3:0]  cfg_data_i   // zero_run_limit
);

  import sfd_pkg::*;

  logic    in_valid, fire, res_valid, out_ready;
  logic [7:0] in_byte;
  result_t core_res, out_res;

  assign cfg_ready_o = 1'b1;
  assign fire        = in_valid && out_ready;

  sfd_in_reg u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_tvalid_i),
    .ready_o (s_tready_o),
    .byte_i  (s_tdata_i),
    .valid_o (in_valid),
    .take_i  (fire),
    .byte_o  (in_byte)
  );

  sfd_core #(
    .FrameBytes (FrameBytes)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .fire_i      (fire),
    .byte_i      (in_byte),
    .res_valid_o (res_valid),
    .res_o       (core_res)
  );

  sfd_out_skid u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .res_i       (core_res),
    .ready_o     (out_ready),
    .valid_o     (m_tvalid_o),
    .pop_ready_i (m_tready_i),
    .res_o       (out_res)
  );

  assign m_tdata_o = {3'b000, out_res.byte_index, out_res.data_byte};
  assign m_tuser_o = out_res.kind;
  assign m_tlast_o = out_res.last_of_frame;

  a_abandon_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tuser_o) |-> (m_tdata_o == 16'd0 && !m_tlast_o))
    else $error("abandon beat carries payload");

  a_last_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tlast_o) |->
      (!m_tuser_o && m_tdata_o[12:8] == IndexW'(FrameBytes - 1)))
    else $error("last beat at wrong index");

  a_stall_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready_o |-> m_tvalid_o)
    else $error("input stalled with empty output");

endmodule

`default_nettype wire

FILE: test/tb.sv
module tb;
  import sfd_pkg::*;

  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned PhaseItems = 230;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        s_tvalid_i  = 1'b0;
  logic        s_tready_o;
  logic [7:0]  s_tdata_i   = 8'h00;
  logic        m_tvalid_o;
  logic        m_tready_i  = 1'b0;
  logic [15:0] m_tdata_o;
  logic        m_tuser_o;
  logic        m_tlast_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_data_i  = 4'd0;

  shifted_sync_frame_deframer i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // deframer prediction state
  phase_e     sync_phase = PH_WAIT;
  logic [2:0] sync_shift = 3'd0;
  logic [1:0] ff_needed  = 2'd0;
  logic [1:0] ff_seen    = 2'd0;
  logic [7:0] last_rx    = 8'h00;
  logic [4:0] pay_cnt    = 5'd0;
  logic [3:0] zeros_seen = 4'd0;
  logic [3:0] zero_limit = ZeroLimitRst;

  logic [7:0] rx_bytes_q[$];
  result_t    frame_out_q[$];
  int         errors     = 0;
  int         pushed     = 0;

  function automatic logic [7:0] rise_ones(input logic [2:0] sh);
    return (sh == 3'd0) ? 8'hFF : ((8'h01 << sh) - 8'h01);
  endfunction

  function automatic logic [7:0] fall_ones(input logic [2:0] sh);
    logic [7:0] p;
    p = 8'hFF << sh;
    return p;
  endfunction

  task automatic deframe_byte(input logic [7:0] b);
    logic [15:0] wide;
    result_t     r;
    int          n;
    case (sync_phase)
      PH_HEADER: begin
        if (ff_seen < ff_needed && b == 8'hFF) begin
          ff_seen = ff_seen + 2'd1;
        end else if (ff_seen == ff_needed && b == fall_ones(sync_shift)) begin
          sync_phase = PH_FIRST;
        end else begin
          zeros_seen = 4'd0;
          sync_phase = PH_IGNORE;
        end
      end
      PH_FIRST: begin
        last_rx    = b;
        pay_cnt    = 5'd0;
        sync_phase = PH_DECODE;
      end
      PH_DECODE: begin
        if (sync_shift == 3'd0) begin
          wide = {8'h00, b};
        end else begin
          wide = ({8'h00, last_rx & rise_ones(sync_shift)} << (4'd8 - {1'b0, sync_shift}))
                 | {8'h00, b >> sync_shift};
        end
        r.kind          = 1'b0;
        r.data_byte     = wide[7:0];
        r.byte_index    = pay_cnt;
        r.last_of_frame = (int'(pay_cnt) + 1 >= FrameBytesDef);
        frame_out_q.push_back(r);
        last_rx = b;
        pay_cnt = pay_cnt + 5'd1;
        if (r.last_of_frame) begin
          sync_phase = PH_WAIT;
          pay_cnt    = 5'd0;
        end
      end
      PH_IGNORE: begin
        if (b == 8'h00) begin
          n = int'(zeros_seen) + 1;
          if (n > int'(zero_limit)) begin
            sync_phase = PH_WAIT;
            r = '0;
            r.kind = 1'b1;
            frame_out_q.push_back(r);
          end else begin
            zeros_seen = n[3:0];
          end
        end else begin
          zeros_seen = 4'd0;
        end
      end
      default: begin
        sync_phase = PH_WAIT;
        if (b != 8'h00) begin
          for (int i = 0; i < 8; i++) begin
            if (b == rise_ones(i[2:0])) begin
              sync_phase = PH_HEADER;
              sync_shift = i[2:0];
              ff_needed  = (i == 0) ? 2'd1 : 2'd2;
              ff_seen    = 2'd0;
            end
          end
        end
      end
    endcase
  endtask

  // input driver: bursts with random gaps
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_o) begin
        deframe_byte(s_tdata_i);
      end
      if (!s_tvalid_i || s_tready_o) begin
        if (gap_left > 0 || rx_bytes_q.size() == 0) begin
          s_tvalid_i <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          s_tvalid_i <= 1'b1;
          s_tdata_i  <= rx_bytes_q.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 32);
            gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // output monitor and ready pattern
  result_t want;
  logic    rdy;
  int      ready_mode = 0;
  int      mode_left  = 0;
  int      stall_left = 0;
  int      cyc        = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      cyc++;
      if (m_tvalid_o && m_tready_i) begin
        if (frame_out_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected beat: kind %0d data %h idx %0d last %0d", m_tuser_o,
                     m_tdata_o[7:0], m_tdata_o[12:8], m_tlast_o);
          end
        end else begin
          want = frame_out_q.pop_front();
          if (m_tuser_o !== want.kind || m_tdata_o[7:0] !== want.data_byte ||
              m_tdata_o[12:8] !== want.byte_index || m_tlast_o !== want.last_of_frame) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: exp kind %0d data %h idx %0d last %0d, got kind %0d data %h idx %0d last %0d",
                       want.kind, want.data_byte, want.byte_index, want.last_of_frame,
                       m_tuser_o, m_tdata_o[7:0], m_tdata_o[12:8], m_tlast_o);
            end
          end
        end
      end
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        0: rdy = 1'b1;
        1: rdy = ($urandom_range(0, 3) != 0);
        2: rdy = ((cyc % 5) < 3);
        default: begin
          if (stall_left > 0) begin
            rdy = 1'b0;
            stall_left--;
          end else begin
            rdy = 1'b1;
            if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 10);
          end
        end
      endcase
      m_tready_i <= rdy;
    end
  end

  // watchdog on cycles without any beat
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("[shifted_sync_frame_deframer] ERROR");
        $finish;
      end
    end
  end

  // stimulus
  task automatic push_rx(input logic [7:0] b);
    rx_bytes_q.push_back(b);
    pushed++;
  endtask

  function automatic logic [7:0] payload_byte();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  task automatic push_frame(input logic [2:0] sh);
    push_rx(rise_ones(sh));
    push_rx(8'hFF);
    if (sh != 3'd0) push_rx(8'hFF);
    push_rx(fall_ones(sh));
    push_rx(payload_byte());
    for (int i = 0; i < FrameBytesDef; i++) push_rx(payload_byte());
  endtask

  task automatic push_zero_exit();
    if ($urandom_range(0, 7) == 0 && zero_limit != 4'd0) begin
      for (int i = 0; i < int'(zero_limit); i++) push_rx(8'h00);
      push_rx(8'($urandom_range(1, 255)));
    end
    for (int i = 0; i <= int'(zero_limit); i++) push_rx(8'h00);
  endtask

  task automatic push_broken(input logic [2:0] sh);
    logic [7:0] hdr[4];
    logic [7:0] bad;
    int         len;
    int         k;
    len    = (sh == 3'd0) ? 3 : 4;
    hdr[0] = rise_ones(sh);
    hdr[1] = 8'hFF;
    hdr[2] = 8'hFF;
    hdr[len-1] = fall_ones(sh);
    k   = $urandom_range(1, len - 1);
    bad = 8'($urandom);
    while (bad == hdr[k]) bad = 8'($urandom);
    for (int i = 0; i < k; i++) push_rx(hdr[i]);
    push_rx(bad);
    for (int i = $urandom_range(0, 4); i > 0; i--) begin
      push_rx(($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom));
    end
    push_zero_exit();
  endtask

  task automatic push_noise();
    int r;
    for (int i = $urandom_range(1, 6); i > 0; i--) begin
      r = $urandom_range(0, 3);
      case (r)
        0: push_rx(8'h00);
        1: push_rx(8'hFF);
        2: push_rx(rise_ones(3'($urandom_range(0, 7))));
        default: push_rx(8'($urandom));
      endcase
    end
  endtask

  task automatic fill_random(input int n);
    int start;
    int r;
    start = pushed;
    while (pushed - start < n) begin
      r = $urandom_range(0, 99);
      if (r < 60) push_frame(3'($urandom_range(0, 7)));
      else if (r < 85) push_broken(3'($urandom_range(0, 7)));
      else push_noise();
    end
  endtask

  task automatic drain();
    while (rx_bytes_q.size() != 0 || s_tvalid_i || frame_out_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [3:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    zero_limit = v;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  logic [3:0] limits[4];

  initial begin
    limits = '{4'd0, 4'd15, 4'($urandom_range(1, 14)), ZeroLimitRst};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // waiting: zero and unmatched bytes
    push_rx(8'h00);
    push_rx(8'h55);
    push_rx(8'h80);
    // shift 1 header broken at the first 0xFF, nonzero while ignoring, zero run exit
    push_rx(8'h01);
    push_rx(8'h00);
    push_rx(8'hA5);
    for (int i = 0; i < 5; i++) push_rx(8'h00);
    // shift 3 header broken at the falling pattern
    push_rx(8'h07);
    push_rx(8'hFF);
    push_rx(8'hFF);
    push_rx(8'h0F);
    for (int i = 0; i < 5; i++) push_rx(8'h00);
    fill_random(PhaseItems);
    drain();

    foreach (limits[i]) begin
      write_limit(limits[i]);
      fill_random(PhaseItems);
      drain();
    end

    repeat (10) @(posedge clk_i);
    errors += frame_out_q.size();
    if (errors == 0) begin
      $display("[shifted_sync_frame_deframer] OK");
    end else begin
      $display("[shifted_sync_frame_deframer] ERROR");
    end
    $finish;
  end

endmodule

FILE: shifted_sync_frame_deframer.f
src/sfd_pkg.sv
src/sfd_in_reg.sv
src/sfd_core.sv
src/sfd_out_skid.sv
src/shifted_sync_frame_deframer.sv
test/tb.sv
